// ===== src/prio_sched_pkg.sv =====
// Shared types and codes for the priority scheduler with lock inheritance.
// Holds the per-slot flag layout and the input operation codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package prio_sched_pkg;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam int FLAG_BITS = 5;

  typedef struct packed {
    logic done;
    logic block;
    logic hold;
    logic want;
    logic used;
  } task_flags_t;

endpackage

`default_nettype wire

// ===== src/priority_scheduler_with_lock_inheritance_core.sv =====
// Task-slot scheduler with one shared lock and optional priority inheritance.
// Slot state sits in one synchronous memory; a sequencer walks it per tick.
// Depends on prio_sched_pkg.
//
//   channel  | handshake           | payload
//   ---------+---------------------+-----------------------------------------------
//   in_      | in_valid/in_ready   | operation, slot, priority_req, work_units,
//            |                     | lock_req
//   out_     | out_valid/out_ready | accepted, ran_valid, ran_slot, task_finished,
//            |                     | all_stuck, tick_number
//   cfg_     | cfg_valid/cfg_ready | inheritance_on
//
// An add passes through write-back and output after its transfer; the slot
// read is issued at the transfer edge.
// A tick passes through grant scan, grant write, pick scan, run write and
// output when the lock is free, and skips the grant steps when it is held; each
// scan reads one slot per cycle from the slot memory.
// Reset (synchronous, rst_n low) frees every slot through per-slot valid bits,
// drops the lock and clears the tick count. A new item is taken only while the
// sequencer is idle; a stalled result waits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module priority_scheduler_with_lock_inheritance_core
  import prio_sched_pkg::*;
#(
  parameter int NUM_TASKS = 4,
  parameter int PRIO_BITS = 8,
  parameter int WORK_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_operation,
  input  wire logic [1:0]  in_slot,
  input  wire logic [7:0]  in_priority_req,
  input  wire logic [15:0] in_work_units,
  input  wire logic        in_lock_req,

  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_accepted,
  output logic             out_ran_valid,
  output logic [1:0]       out_ran_slot,
  output logic             out_task_finished,
  output logic             out_all_stuck,
  output logic [31:0]      out_tick_number,

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_inheritance_on
);

  localparam int SW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int CW = $clog2(NUM_TASKS + 1);
  localparam int PW = PRIO_BITS;
  localparam int WW = WORK_BITS;
  localparam int EW = PW + WW + FLAG_BITS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ADD   = 3'd1;
  localparam logic [2:0] S_GSCAN = 3'd2;
  localparam logic [2:0] S_GWR   = 3'd3;
  localparam logic [2:0] S_PSCAN = 3'd4;
  localparam logic [2:0] S_RUN   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  localparam logic [CW-1:0] SCAN_END = CW'(NUM_TASKS);

  // slot memory and per-slot valid bits (an unwritten slot reads as zero)
  logic [EW-1:0]        mem [NUM_TASKS];
  logic [NUM_TASKS-1:0] vld_r;
  logic [EW-1:0]        rd_data_r;
  logic                 rd_vld_r;
  logic [SW-1:0]        rd_addr;
  logic                 wr_en;
  logic [SW-1:0]        wr_addr;
  logic [EW-1:0]        wr_data;

  logic [EW-1:0]        ent;
  logic [PW-1:0]        e_prio;
  logic [WW-1:0]        e_work;
  task_flags_t          e_fl;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0] scan_idx;

  logic          inh_r;
  logic          lock_held_r, lock_held_nxt;
  logic [SW-1:0] holder_slot_r, holder_slot_nxt;
  logic [31:0]   tick_count_r, tick_count_nxt;

  logic [SW-1:0] slot_r, slot_nxt;
  logic [PW-1:0] prio_in_r, prio_in_nxt;
  logic [WW-1:0] work_in_r, work_in_nxt;
  logic          want_r, want_nxt;

  // grant scan
  logic          found_r, found_nxt;
  logic [SW-1:0] w_slot_r, w_slot_nxt;
  logic [PW-1:0] w_prio_r, w_prio_nxt;
  logic [WW-1:0] w_work_r, w_work_nxt;
  task_flags_t   w_fl_r, w_fl_nxt;

  // pick scan: best non-holder candidate, holder candidate, top blocked priority
  logic          have_r, have_nxt;
  logic [SW-1:0] best_slot_r, best_slot_nxt;
  logic [PW-1:0] best_prio_r, best_prio_nxt;
  logic [WW-1:0] best_work_r, best_work_nxt;
  task_flags_t   best_fl_r, best_fl_nxt;
  logic          hcand_r, hcand_nxt;
  logic [PW-1:0] hprio_r, hprio_nxt;
  logic [WW-1:0] hwork_r, hwork_nxt;
  task_flags_t   hfl_r, hfl_nxt;
  logic [PW-1:0] maxblk_r, maxblk_nxt;

  // run step
  logic [PW-1:0] heff;
  logic          take_h;
  logic [SW-1:0] sel_slot;
  logic [PW-1:0] sel_prio;
  logic [WW-1:0] sel_work;
  logic [WW-1:0] work_dec;
  task_flags_t   sel_fl;
  task_flags_t   new_fl;
  logic          slot_free;

  // pending result
  logic          res_acc_r, res_acc_nxt;
  logic          res_ran_r, res_ran_nxt;
  logic [SW-1:0] res_slot_r, res_slot_nxt;
  logic          res_fin_r, res_fin_nxt;
  logic          res_stuck_r, res_stuck_nxt;
  logic [31:0]   res_tick_r, res_tick_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic          out_acc_r, out_ran_r, out_fin_r, out_stuck_r;
  logic [SW-1:0] out_slot_r;
  logic [31:0]   out_tick_r;
  logic          out_load;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  assign out_valid         = out_valid_r;
  assign out_accepted      = out_acc_r;
  assign out_ran_valid     = out_ran_r;
  assign out_ran_slot      = 2'(out_slot_r);
  assign out_task_finished = out_fin_r;
  assign out_all_stuck     = out_stuck_r;
  assign out_tick_number   = out_tick_r;

  assign ent      = rd_vld_r ? rd_data_r : '0;
  assign e_prio   = ent[EW-1 -: PW];
  assign e_work   = ent[WW+FLAG_BITS-1 : FLAG_BITS];
  assign e_fl     = task_flags_t'(ent[FLAG_BITS-1:0]);
  assign scan_idx = SW'(cnt_r - CW'(1));

  // selection between holder (with inherited priority) and best other task
  always_comb begin
    heff     = (inh_r && (maxblk_r > hprio_r)) ? maxblk_r : hprio_r;
    take_h   = hcand_r && (!have_r || (heff > best_prio_r) ||
               ((heff == best_prio_r) && (holder_slot_r < best_slot_r)));
    sel_slot = take_h ? holder_slot_r : best_slot_r;
    sel_prio = take_h ? hprio_r : best_prio_r;
    sel_work = take_h ? hwork_r : best_work_r;
    sel_fl   = take_h ? hfl_r : best_fl_r;
    work_dec = sel_work - WW'(1);
    new_fl   = sel_fl;
    if (work_dec == '0) begin
      new_fl.done = 1'b1;
      new_fl.hold = 1'b0;
    end
    slot_free = !e_fl.used || e_fl.done;
  end

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    lock_held_nxt   = lock_held_r;
    holder_slot_nxt = holder_slot_r;
    tick_count_nxt  = tick_count_r;
    slot_nxt        = slot_r;
    prio_in_nxt     = prio_in_r;
    work_in_nxt     = work_in_r;
    want_nxt        = want_r;
    found_nxt       = found_r;
    w_slot_nxt      = w_slot_r;
    w_prio_nxt      = w_prio_r;
    w_work_nxt      = w_work_r;
    w_fl_nxt        = w_fl_r;
    have_nxt        = have_r;
    best_slot_nxt   = best_slot_r;
    best_prio_nxt   = best_prio_r;
    best_work_nxt   = best_work_r;
    best_fl_nxt     = best_fl_r;
    hcand_nxt       = hcand_r;
    hprio_nxt       = hprio_r;
    hwork_nxt       = hwork_r;
    hfl_nxt         = hfl_r;
    maxblk_nxt      = maxblk_r;
    res_acc_nxt     = res_acc_r;
    res_ran_nxt     = res_ran_r;
    res_slot_nxt    = res_slot_r;
    res_fin_nxt     = res_fin_r;
    res_stuck_nxt   = res_stuck_r;
    res_tick_nxt    = res_tick_r;
    out_valid_nxt   = out_valid_r;
    out_load        = 1'b0;
    rd_addr         = '0;
    wr_en           = 1'b0;
    wr_addr         = '0;
    wr_data         = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (32'(in_slot) < NUM_TASKS) begin
          rd_addr = SW'(in_slot);
        end
        if (in_valid) begin
          slot_nxt      = SW'(in_slot);
          prio_in_nxt   = PW'(in_priority_req);
          work_in_nxt   = WW'(in_work_units);
          want_nxt      = in_lock_req;
          res_acc_nxt   = 1'b0;
          res_ran_nxt   = 1'b0;
          res_slot_nxt  = '0;
          res_fin_nxt   = 1'b0;
          res_stuck_nxt = 1'b0;
          res_tick_nxt  = tick_count_r;
          cnt_nxt       = '0;
          found_nxt     = 1'b0;
          have_nxt      = 1'b0;
          hcand_nxt     = 1'b0;
          maxblk_nxt    = '0;
          if (in_operation == OP_TICK) begin
            res_acc_nxt = 1'b1;
            state_nxt   = lock_held_r ? S_PSCAN : S_GSCAN;
          end else if (32'(in_slot) < NUM_TASKS) begin
            state_nxt = S_ADD;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end

      S_ADD: begin
        if (slot_free) begin
          res_acc_nxt  = 1'b1;
          wr_en        = 1'b1;
          wr_addr      = slot_r;
          wr_data[EW-1 -: PW] = prio_in_r;
          wr_data[WW+FLAG_BITS-1 : FLAG_BITS] = work_in_r;
          if (work_in_r == '0) begin
            wr_data[FLAG_BITS-1:0] = task_flags_t'{done: 1'b1, block: 1'b0, hold: 1'b0,
                                                   want: 1'b0, used: 1'b1};
          end else begin
            wr_data[FLAG_BITS-1:0] = task_flags_t'{done: 1'b0,
                                                   block: want_r && lock_held_r,
                                                   hold: 1'b0, want: want_r,
                                                   used: 1'b1};
          end
        end
        state_nxt = S_FIN;
      end

      S_GSCAN: begin
        rd_addr = (cnt_r == SCAN_END) ? '0 : SW'(cnt_r);
        if (cnt_r != '0) begin
          if (e_fl.used && !e_fl.done && e_fl.want && !e_fl.hold &&
              (!found_r || (e_prio > w_prio_r))) begin
            found_nxt  = 1'b1;
            w_slot_nxt = scan_idx;
            w_prio_nxt = e_prio;
            w_work_nxt = e_work;
            w_fl_nxt   = e_fl;
          end
        end
        if (cnt_r == SCAN_END) begin
          state_nxt = S_GWR;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end

      S_GWR: begin
        // hand the free lock to the chosen waiter before the pick scan reads it
        if (found_r) begin
          wr_en   = 1'b1;
          wr_addr = w_slot_r;
          wr_data[EW-1 -: PW] = w_prio_r;
          wr_data[WW+FLAG_BITS-1 : FLAG_BITS] = w_work_r;
          wr_data[FLAG_BITS-1:0] = task_flags_t'{done: w_fl_r.done, block: 1'b0,
                                                 hold: 1'b1, want: w_fl_r.want,
                                                 used: w_fl_r.used};
          holder_slot_nxt = w_slot_r;
          lock_held_nxt   = 1'b1;
        end
        cnt_nxt   = '0;
        state_nxt = S_PSCAN;
      end

      S_PSCAN: begin
        rd_addr = (cnt_r == SCAN_END) ? '0 : SW'(cnt_r);
        if (cnt_r != '0) begin
          if (e_fl.block && (e_prio > maxblk_r)) begin
            maxblk_nxt = e_prio;
          end
          if (e_fl.used && !e_fl.done && !e_fl.block && (e_work != '0) &&
              (!e_fl.want || e_fl.hold)) begin
            if (lock_held_r && (scan_idx == holder_slot_r)) begin
              hcand_nxt = 1'b1;
              hprio_nxt = e_prio;
              hwork_nxt = e_work;
              hfl_nxt   = e_fl;
            end else if (!have_r || (e_prio > best_prio_r)) begin
              have_nxt      = 1'b1;
              best_slot_nxt = scan_idx;
              best_prio_nxt = e_prio;
              best_work_nxt = e_work;
              best_fl_nxt   = e_fl;
            end
          end
        end
        if (cnt_r == SCAN_END) begin
          state_nxt = S_RUN;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end

      S_RUN: begin
        if (have_r || hcand_r) begin
          wr_en   = 1'b1;
          wr_addr = sel_slot;
          wr_data[EW-1 -: PW] = sel_prio;
          wr_data[WW+FLAG_BITS-1 : FLAG_BITS] = work_dec;
          wr_data[FLAG_BITS-1:0] = new_fl;
          res_ran_nxt  = 1'b1;
          res_slot_nxt = sel_slot;
          if (work_dec == '0) begin
            res_fin_nxt = 1'b1;
            if (sel_fl.hold) begin
              lock_held_nxt = 1'b0;
            end
          end
          tick_count_nxt = tick_count_r + 32'd1;
        end else begin
          res_stuck_nxt = 1'b1;
        end
        state_nxt = S_FIN;
      end

      S_FIN: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cnt_r         <= '0;
      vld_r         <= '0;
      rd_vld_r      <= 1'b0;
      inh_r         <= 1'b0;
      lock_held_r   <= 1'b0;
      holder_slot_r <= '0;
      tick_count_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cnt_r         <= cnt_nxt;
      rd_vld_r      <= vld_r[rd_addr];
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        inh_r <= cfg_inheritance_on;
      end
      lock_held_r   <= lock_held_nxt;
      holder_slot_r <= holder_slot_nxt;
      tick_count_r  <= tick_count_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r      <= slot_nxt;
    prio_in_r   <= prio_in_nxt;
    work_in_r   <= work_in_nxt;
    want_r      <= want_nxt;
    found_r     <= found_nxt;
    w_slot_r    <= w_slot_nxt;
    w_prio_r    <= w_prio_nxt;
    w_work_r    <= w_work_nxt;
    w_fl_r      <= w_fl_nxt;
    have_r      <= have_nxt;
    best_slot_r <= best_slot_nxt;
    best_prio_r <= best_prio_nxt;
    best_work_r <= best_work_nxt;
    best_fl_r   <= best_fl_nxt;
    hcand_r     <= hcand_nxt;
    hprio_r     <= hprio_nxt;
    hwork_r     <= hwork_nxt;
    hfl_r       <= hfl_nxt;
    maxblk_r    <= maxblk_nxt;
    res_acc_r   <= res_acc_nxt;
    res_ran_r   <= res_ran_nxt;
    res_slot_r  <= res_slot_nxt;
    res_fin_r   <= res_fin_nxt;
    res_stuck_r <= res_stuck_nxt;
    res_tick_r  <= res_tick_nxt;
    if (out_load) begin
      out_acc_r   <= res_acc_r;
      out_ran_r   <= res_ran_r;
      out_slot_r  <= res_slot_r;
      out_fin_r   <= res_fin_r;
      out_stuck_r <= res_stuck_r;
      out_tick_r  <= res_tick_r;
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Testbench for the priority scheduler with lock inheritance: a directed table, then
// randomized phases under both inheritance settings, every result checked in order.
// Depends on prio_sched_pkg and priority_scheduler_with_lock_inheritance_core.
`timescale 1ns / 1ps

module tb_top;
  import prio_sched_pkg::*;

  localparam int NUM_SLOTS       = 4;
  localparam int PHASES          = 5;
  localparam int PHASE_JOBS      = 230;
  localparam int IDLE_PCT        = 24;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 20;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int PLAN_LEN        = 26;

  typedef struct packed {
    logic        op;
    logic [1:0]  slot;
    logic [7:0]  prio;
    logic [15:0] work;
    logic        want;
  } job_t;

  typedef struct packed {
    logic        accepted;
    logic        ran_valid;
    logic [1:0]  ran_slot;
    logic        task_finished;
    logic        all_stuck;
    logic [31:0] tick_number;
  } sched_result_t;

  typedef enum logic {ROW_JOB, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t     kind;
    logic          inherit;
    logic          op;
    logic [1:0]    slot;
    logic [7:0]    prio;
    logic [15:0]   work;
    logic          want;
    logic          typed;
    sched_result_t r;
  } plan_row_t;

  // outcomes that can be read straight off the scheduler rules
  localparam sched_result_t ADD_TAKEN   = '{1'b1, 1'b0, 2'd0, 1'b0, 1'b0, 32'd0};
  localparam sched_result_t ADD_REFUSED = '{1'b0, 1'b0, 2'd0, 1'b0, 1'b0, 32'd0};
  localparam sched_result_t STUCK_AT_0  = '{1'b1, 1'b0, 2'd0, 1'b0, 1'b1, 32'd0};
  localparam sched_result_t STUCK_AT_1  = '{1'b1, 1'b0, 2'd0, 1'b0, 1'b1, 32'd1};
  localparam sched_result_t S0_DONE_AT_0 = '{1'b1, 1'b1, 2'd0, 1'b1, 1'b0, 32'd0};
  localparam sched_result_t BY_MODEL    = '0;

  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{ROW_CFG, 1'b0, OP_TICK, 2'd0, 8'd0,   16'd0,      1'b0, 1'b0, BY_MODEL},
    '{ROW_JOB, 1'b0, OP_TICK, 2'd0, 8'd0,   16'd0,      1'b0, 1'b1, STUCK_AT_0},
    '{ROW_JOB, 1'b0, OP_ADD,  2'd0, 8'd255, 16'd1,      1'b0, 1'b1, ADD_TAKEN},
    '{ROW_JOB, 1'b0, OP_ADD,  2'd0, 8'd0,   16'hFFFF,   1'b1, 1'b1, ADD_REFUSED},
    '{ROW_JOB, 1'b0, OP_ADD,  2'd1, 8'd0,   16'd0,      1'b1, 1'b1, ADD_TAKEN},
    '{ROW_JOB, 1'b0, OP_TICK, 2'd3, 8'd255, 16'hFFFF,   1'b1, 1'b1, S0_DONE_AT_0},
    '{ROW_JOB, 1'b0, OP_TICK, 2'd0, 8'd0,   16'd0,      1'b0, 1'b1, STUCK_AT_1},
    '{ROW_JOB, 1'b0, OP_ADD,  2'd2, 8'd10,  16'd3,      1'b1, 1'b0, BY_MODEL},
    '{ROW_JOB, 1'b0, OP_ADD,  2'd3, 8'd200, 16'd2,      1'b0, 1'b0, BY_MODEL},
    '{ROW_JOB, 1'b0, OP_TICK, 2'd0, 8'd0,   16'd0,      1'b0, 1'b0, BY_MODEL},
    '{ROW_JOB, 1'b0, OP_ADD,  2'd0, 8'd100, 16'd2,      1'b1, 1'b0, BY_MODEL},
    '{ROW_JOB, 1'b0, OP_TICK, 2'd0, 8'd0,   16'd0,      1'b0, 1'b0, BY_MODEL},
    '{ROW_JOB, 1'b0, OP_TICK, 2'd0, 8'd0,   16'd0,      1'b0, 1'b0, BY_MODEL},
    '{ROW_JOB, 1'b0, OP_ADD,  2'd1, 8'd50,  16'd3,      1'b0, 1'b0, BY_MODEL},
    '{ROW_JOB, 1'b0, OP_TICK, 2'd0, 8'd0,   16'd0,      1'b0, 1'b0, BY_MODEL},
    '{ROW_CFG, 1'b1, OP_TICK, 2'd0, 8'd0,   16'd0,      1'b0, 1'b0, BY_MODEL},
    '{ROW_JOB, 1'b0, OP_TICK, 2'd0, 8'd0,   16'd0,      1'b0, 1'b0, BY_MODEL},
    '{ROW_JOB, 1'b0, OP_TICK, 2'd0, 8'd0,   16'd0,      1'b0, 1'b0, BY_MODEL},
    '{ROW_JOB, 1'b0, OP_ADD,  2'd2, 8'd255, 16'd1,      1'b1, 1'b0, BY_MODEL},
    '{ROW_JOB, 1'b0, OP_ADD,  2'd3, 8'd255, 16'd1,      1'b1, 1'b0, BY_MODEL},
    '{ROW_JOB, 1'b0, OP_TICK, 2'd0, 8'd0,   16'd0,      1'b0, 1'b0, BY_MODEL},
    '{ROW_JOB, 1'b0, OP_TICK, 2'd0, 8'd0,   16'd0,      1'b0, 1'b0, BY_MODEL},
    '{ROW_JOB, 1'b0, OP_TICK, 2'd0, 8'd0,   16'd0,      1'b0, 1'b0, BY_MODEL},
    '{ROW_JOB, 1'b0, OP_TICK, 2'd0, 8'd0,   16'd0,      1'b0, 1'b0, BY_MODEL},
    '{ROW_JOB, 1'b0, OP_TICK, 2'd0, 8'd0,   16'd0,      1'b0, 1'b0, BY_MODEL},
    '{ROW_JOB, 1'b0, OP_TICK, 2'd0, 8'd0,   16'd0,      1'b0, 1'b0, BY_MODEL}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_operation = OP_ADD;
  logic [1:0]  in_slot = '0;
  logic [7:0]  in_priority_req = '0;
  logic [15:0] in_work_units = '0;
  logic        in_lock_req = 1'b0;
  logic        out_ready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_inheritance_on = 1'b0;

  logic        in_ready;
  logic        out_valid;
  logic        out_accepted;
  logic        out_ran_valid;
  logic [1:0]  out_ran_slot;
  logic        out_task_finished;
  logic        out_all_stuck;
  logic [31:0] out_tick_number;
  logic        cfg_ready;

  priority_scheduler_with_lock_inheritance_core DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_slot            (in_slot),
    .in_priority_req    (in_priority_req),
    .in_work_units      (in_work_units),
    .in_lock_req        (in_lock_req),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_accepted       (out_accepted),
    .out_ran_valid      (out_ran_valid),
    .out_ran_slot       (out_ran_slot),
    .out_task_finished  (out_task_finished),
    .out_all_stuck      (out_all_stuck),
    .out_tick_number    (out_tick_number),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_inheritance_on (cfg_inheritance_on)
  );

  // scheduler state as the bench tracks it
  task_flags_t slot_flags [NUM_SLOTS];
  logic [7:0]  slot_prio  [NUM_SLOTS];
  logic [15:0] slot_work  [NUM_SLOTS];
  int          lock_owner = 0;
  bit          lock_taken = 1'b0;
  logic [31:0] ticks_run = '0;
  bit          inherit_en = 1'b0;

  sched_result_t awaited_reports [$];
  sched_result_t head;

  int  mismatches = 0;
  int  reports_seen = 0;
  int  jobs_sent = 0;
  int  adds_taken = 0;
  int  ticks_stuck = 0;
  int  tasks_done = 0;
  int  boosted_picks = 0;
  int  cfg_writes = 0;
  int  cycle_count = 0;
  bit  calm = 1'b0;
  bit  stall_burst_req = 1'b0;

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_flags[i] = '0;
      slot_prio[i] = '0;
      slot_work[i] = '0;
    end
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, awaited_reports.size());
      $display("status: fail");
      $finish;
    end
  end

  // result side: random back-pressure, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (stall_burst_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
        stall_burst_req = 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      reports_seen++;
      if (awaited_reports.size() == 0) begin
        $error("result transfer with nothing expected");
        mismatches++;
      end else begin
        head = awaited_reports.pop_front();
        check_field("accepted", 64'(head.accepted), 64'(out_accepted));
        check_field("ran_valid", 64'(head.ran_valid), 64'(out_ran_valid));
        check_field("ran_slot", 64'(head.ran_slot), 64'(out_ran_slot));
        check_field("task_finished", 64'(head.task_finished), 64'(out_task_finished));
        check_field("all_stuck", 64'(head.all_stuck), 64'(out_all_stuck));
        check_field("tick_number", 64'(head.tick_number), 64'(out_tick_number));
      end
    end
  end

  // with inheritance on, the holder takes on the highest base priority among blocked tasks if it exceeds its own
  function automatic logic [7:0] boosted_prio(input int s);
    logic [7:0] p;
    p = slot_prio[s];
    if (inherit_en && lock_taken && lock_owner == s)
      for (int k = 0; k < NUM_SLOTS; k++)
        if (slot_flags[k].block && slot_prio[k] > p) p = slot_prio[k];
    return p;
  endfunction

  function automatic sched_result_t advance_scheduler(input job_t j);
    sched_result_t r;
    task_flags_t   f;
    bit            found;
    bit            have;
    int            w;
    int            best;
    logic [7:0]    e;
    logic [7:0]    best_e;
    r = '0;
    r.tick_number = ticks_run;
    found = 1'b0;
    have = 1'b0;
    w = 0;
    best = 0;
    best_e = '0;
    if (j.op == OP_ADD) begin
      f = slot_flags[j.slot];
      if (!f.used || f.done) begin
        r.accepted = 1'b1;
        slot_prio[j.slot] = j.prio;
        slot_work[j.slot] = j.work;
        f = '0;
        f.used = 1'b1;
        // zero work finishes on the spot and never touches the lock
        if (j.work == '0) f.done = 1'b1;
        else if (j.want) begin
          f.want = 1'b1;
          f.block = lock_taken;
        end
        slot_flags[j.slot] = f;
        adds_taken++;
      end
    end else begin
      r.accepted = 1'b1;
      if (!lock_taken) begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          f = slot_flags[i];
          if (f.used && !f.done && f.want && !f.hold &&
              (!found || slot_prio[i] > slot_prio[w])) begin
            w = i;
            found = 1'b1;
          end
        end
        if (found) begin
          slot_flags[w].block = 1'b0;
          slot_flags[w].hold = 1'b1;
          lock_owner = w;
          lock_taken = 1'b1;
        end
      end
      for (int i = 0; i < NUM_SLOTS; i++) begin
        f = slot_flags[i];
        if (f.used && !f.done && !f.block && slot_work[i] != '0 && (!f.want || f.hold)) begin
          e = boosted_prio(i);
          if (!have || e > best_e) begin
            have = 1'b1;
            best_e = e;
            best = i;
          end
        end
      end
      if (!have) begin
        // tick count holds on a stuck tick
        r.all_stuck = 1'b1;
        ticks_stuck++;
      end else begin
        r.ran_valid = 1'b1;
        r.ran_slot = 2'(best);
        if (best_e != slot_prio[best]) boosted_picks++;
        slot_work[best] = slot_work[best] - 16'd1;
        if (slot_work[best] == '0) begin
          r.task_finished = 1'b1;
          slot_flags[best].done = 1'b1;
          if (slot_flags[best].hold) begin
            slot_flags[best].hold = 1'b0;
            lock_taken = 1'b0;
          end
          tasks_done++;
        end
        ticks_run = ticks_run + 32'd1;
      end
    end
    return r;
  endfunction

  task automatic offer_job(input job_t j, input bit typed, input sched_result_t typed_r);
    sched_result_t r;
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= j.op;
    in_slot         <= j.slot;
    in_priority_req <= j.prio;
    in_work_units   <= j.work;
    in_lock_req     <= j.want;
    do @(posedge clk); while (!in_ready);
    r = advance_scheduler(j);
    awaited_reports.push_back(typed ? typed_r : r);
    jobs_sent++;
  endtask

  // drop valid and wait until the block has answered everything
  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_inherit(input bit v);
    cfg_inheritance_on <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    inherit_en = v;
    cfg_writes++;
  endtask

  initial begin
    job_t j;
    int   base;
    bit   placed;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int n = 0; n < PLAN_LEN; n++) begin
      if (PLAN[n].kind == ROW_CFG) begin
        settle();
        write_inherit(PLAN[n].inherit);
      end else begin
        j.op = PLAN[n].op;
        j.slot = PLAN[n].slot;
        j.prio = PLAN[n].prio;
        j.work = PLAN[n].work;
        j.want = PLAN[n].want;
        offer_job(j, PLAN[n].typed, PLAN[n].r);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_inherit(p % 2 == 0);
      for (int i = 0; i < PHASE_JOBS; i++) begin
        calm = (p == 2 && i < 150);
        if (p == 1 && i == 40) stall_burst_req = 1'b1;
        if (p == 3 && i == 100) settle();
        j.op = ($urandom_range(99) < 45) ? OP_TICK : OP_ADD;
        j.slot = 2'($urandom_range(3));
        j.want = 1'($urandom_range(1));
        j.work = 16'($urandom_range(16'hFFFF));
        case ($urandom_range(2))
          0: j.prio = 8'($urandom_range(15));
          1: j.prio = 8'($urandom_range(255, 240));
          default: j.prio = 8'($urandom_range(255));
        endcase
        if (j.op == OP_ADD) begin
          // mostly aim at a free slot; the rest keeps its random slot and is refused if that slot is busy
          if ($urandom_range(99) < 70) begin
            base = $urandom_range(3);
            placed = 1'b0;
            for (int k = 0; k < NUM_SLOTS; k++)
              if (!placed && !(slot_flags[2'(base + k)].used &&
                               !slot_flags[2'(base + k)].done)) begin
                j.slot = 2'(base + k);
                placed = 1'b1;
              end
          end
          // keep accepted work short so slots turn over
          if (!slot_flags[j.slot].used || slot_flags[j.slot].done)
            j.work = ($urandom_range(99) < 8) ? 16'd0 :
                     16'($urandom_range(($urandom_range(9) == 0) ? 40 : 6, 1));
        end
        offer_job(j, 1'b0, BY_MODEL);
      end
    end
    calm = 1'b0;
    settle();

    if (awaited_reports.size() != 0) begin
      $error("%0d expected results never arrived", awaited_reports.size());
      mismatches++;
    end
    $display("covered %0d items (%0d adds taken) and %0d results over %0d inheritance writes",
             jobs_sent, adds_taken, reports_seen, cfg_writes);
    $display("ticks: %0d ran, %0d stuck, %0d tasks finished, %0d picks won on inherited priority",
             ticks_run, ticks_stuck, tasks_done, boosted_picks);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/prio_sched_pkg.sv
src/priority_scheduler_with_lock_inheritance_core.sv
tb/sv/tb_top.sv
